FILE: src/nhc_pkg.sv
package nhc_pkg;

	localparam int unsigned NOTE_W    = 7;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned SEG_W     = 8;
	localparam int unsigned HUE_W     = 9;
	localparam int unsigned REM_W     = 6;
	localparam int unsigned SPAN_W    = 6;
	localparam int unsigned NUM_W     = 18;
	localparam int unsigned QUOT_W    = 9;
	localparam int unsigned VS_W      = 16;
	localparam int unsigned CNUM_W    = 22;
	localparam int unsigned RECIP_W   = 23;
	localparam int unsigned PROD_W    = CNUM_W + RECIP_W;

	localparam logic [HUE_W-1:0]  HUE_SHIFT   = 9'd120;
	localparam logic [HUE_W-1:0]  FULL_TURN   = 9'd360;
	localparam logic [HUE_W-1:0]  SECTOR_SPAN = 9'd60;
	localparam logic [13:0]       CHANNEL_DIV = 14'd15300;

	// ceil(2^36 / 15300); exact floor for every numerator up to 255 * 15300
	localparam logic [RECIP_W-1:0] RECIP       = 23'd4491470;
	localparam int unsigned        RECIP_SHIFT = 36;

	localparam logic [SEG_W-1:0] SEG_RESET = 8'd12;

	localparam logic REG_SEGMENT_COUNT = 1'b0;

	typedef enum logic [2:0] {
		SEC_RED_GUP,
		SEC_GRN_RDN,
		SEC_GRN_BUP,
		SEC_BLU_GDN,
		SEC_BLU_RUP,
		SEC_RED_BDN
	} nhc_sector_t;

	typedef struct packed {
		logic ld_s6;
		logic ld_s7;
	} nhc_ctl_t;

endpackage

FILE: src/nhc_channel.sv
module nhc_channel (
	input  logic                          clk,
	input  nhc_pkg::nhc_ctl_t             ctl,
	input  logic [nhc_pkg::CNUM_W-1:0]    vk,
	input  logic [nhc_pkg::VS_W-1:0]      vs,
	input  logic [nhc_pkg::SPAN_W-1:0]    j,
	output logic [nhc_pkg::CHAN_W-1:0]    value
);

	logic [nhc_pkg::CNUM_W-1:0] vsj;
	logic [nhc_pkg::CNUM_W-1:0] num_s6;
	logic [nhc_pkg::PROD_W-1:0] prod;
	logic [nhc_pkg::CHAN_W-1:0] value_s7;

	// v*15300 - v*s*(60 - k), never negative
	assign vsj = nhc_pkg::CNUM_W'(vs) * nhc_pkg::CNUM_W'(j);

	// divide by 15300 through the reciprocal
	assign prod = nhc_pkg::PROD_W'(num_s6) * nhc_pkg::PROD_W'(nhc_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (ctl.ld_s6) begin
			num_s6 <= vk - vsj;
		end
		if (ctl.ld_s7) begin
			value_s7 <= prod[nhc_pkg::RECIP_SHIFT +: nhc_pkg::CHAN_W];
		end
	end

	assign value = value_s7;

endmodule

FILE: src/note_hue_to_rgb_colour.sv
// each accepted transaction moves through stages s1 to s7 in order, and its result is driven from s7
// throughput: one transaction per cycle while rgb_ready holds; seven register stages, each with its own valid bit
// a stall holds only the stages that are full, so bubbles close up under backpressure
// reset (arst_n low, asynchronous) empties the pipeline and sets segment_count to 12
module note_hue_to_rgb_colour (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          note_valid,
	output logic                          note_ready,
	input  logic [nhc_pkg::NOTE_W-1:0]    note_number,
	input  logic [nhc_pkg::CHAN_W-1:0]    saturation,
	input  logic [nhc_pkg::CHAN_W-1:0]    brightness,
	input  logic [nhc_pkg::CHAN_W-1:0]    opacity,
	output logic                          rgb_valid,
	input  logic                          rgb_ready,
	output logic [nhc_pkg::CHAN_W-1:0]    red,
	output logic [nhc_pkg::CHAN_W-1:0]    green,
	output logic [nhc_pkg::CHAN_W-1:0]    blue,
	output logic [nhc_pkg::CHAN_W-1:0]    alpha_out
);

	localparam int unsigned NW = nhc_pkg::NOTE_W;
	localparam int unsigned SW = nhc_pkg::SEG_W;
	localparam int unsigned CW = nhc_pkg::CHAN_W;
	localparam int unsigned HW = nhc_pkg::HUE_W;
	localparam int unsigned QW = nhc_pkg::QUOT_W;
	localparam int unsigned UW = nhc_pkg::NUM_W;
	localparam int unsigned KW = nhc_pkg::CNUM_W;
	localparam int unsigned JW = nhc_pkg::SPAN_W;
	localparam int unsigned VW = nhc_pkg::VS_W;
	localparam int unsigned HI_STEPS = 5;
	localparam int unsigned LO_STEPS = QW - HI_STEPS;

	logic [SW-1:0] seg_q;
	logic [SW-1:0] seg_eff;
	logic          cfg_wr;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;

	logic [SW-1:0]   r_s1;
	logic [VW-1:0]   vs_s1, vs_s2, vs_s3, vs_s4, vs_s5;
	logic [CW-1:0]   v_s1;
	logic [CW-1:0]   a_s1, a_s2, a_s3, a_s4, a_s5, a_s6, a_s7;
	logic [KW-1:0]   vk_s2, vk_s3, vk_s4, vk_s5;
	logic [UW-1:0]   num_s2;
	logic [QW-1:0]   rem_s3;
	logic [HI_STEPS-1:0] qh_s3;
	logic [LO_STEPS-1:0] lo_s3;
	logic [QW-1:0]   base_s4;
	logic [JW-1:0]   jr_s5, jg_s5, jb_s5;

	logic [SW-1:0]   mod_c;
	logic [UW-1:0]   num_c;
	logic [QW-1:0]   rem_hi_c;
	logic [HI_STEPS-1:0] qh_c;
	logic [LO_STEPS-1:0] ql_c;
	logic [HW:0]     sum_c;
	logic [HW-1:0]   hue_c;
	logic [HW-1:0]   off_c;
	logic [JW-1:0]   hrem_c;
	logic [JW-1:0]   span_c;
	logic [JW-1:0]   jr_c, jg_c, jb_c;
	nhc_pkg::nhc_sector_t sector_c;
	nhc_pkg::nhc_ctl_t    ctl;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready
		&& (paddr[2] == nhc_pkg::REG_SEGMENT_COUNT);
	assign seg_eff = (seg_q == '0) ? SW'(1) : seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= nhc_pkg::SEG_RESET;
		end else if (cfg_wr) begin
			seg_q <= pwdata[SW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == nhc_pkg::REG_SEGMENT_COUNT) begin
			prdata = {{(32-SW){1'b0}}, seg_q};
		end
	end

	// stage loads
	assign ld7 = !vld_s7 || rgb_ready;
	assign ld6 = !vld_s6 || ld7;
	assign ld5 = !vld_s5 || ld6;
	assign ld4 = !vld_s4 || ld5;
	assign ld3 = !vld_s3 || ld4;
	assign ld2 = !vld_s2 || ld3;
	assign ld1 = !vld_s1 || ld2;
	assign note_ready = ld1;
	assign rgb_valid  = vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= note_valid;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
			if (ld5) vld_s5 <= vld_s4;
			if (ld6) vld_s6 <= vld_s5;
			if (ld7) vld_s7 <= vld_s6;
		end
	end

	// note mod segment count, restoring, one step per note bit
	always_comb begin
		logic [SW:0] t;
		logic [SW:0] acc;
		acc = '0;
		for (int i = NW - 1; i >= 0; i--) begin
			t = {acc[SW-1:0], note_number[i]};
			if (t >= {1'b0, seg_eff}) begin
				acc = t - {1'b0, seg_eff};
			end else begin
				acc = t;
			end
		end
		mod_c = acc[SW-1:0];
	end

	// numerator of the rounded hue offset: 720*r + seg
	assign num_c = UW'(r_s1) * UW'({nhc_pkg::FULL_TURN, 1'b0}) + UW'(seg_eff);

	// divide by 2*seg; quotient is below 360, so the top bits start as remainder
	always_comb begin
		logic [QW:0] t;
		logic [QW-1:0] acc;
		acc  = num_s2[UW-1 -: QW];
		qh_c = '0;
		for (int i = 0; i < HI_STEPS; i++) begin
			t = {acc, num_s2[QW-1-i]};
			if (t >= {1'b0, seg_eff, 1'b0}) begin
				t = t - {1'b0, seg_eff, 1'b0};
				qh_c[HI_STEPS-1-i] = 1'b1;
			end
			acc = t[QW-1:0];
		end
		rem_hi_c = acc;
	end

	always_comb begin
		logic [QW:0] t;
		logic [QW-1:0] acc;
		acc  = rem_s3;
		ql_c = '0;
		for (int i = 0; i < LO_STEPS; i++) begin
			t = {acc, lo_s3[LO_STEPS-1-i]};
			if (t >= {1'b0, seg_eff, 1'b0}) begin
				t = t - {1'b0, seg_eff, 1'b0};
				ql_c[LO_STEPS-1-i] = 1'b1;
			end
			acc = t[QW-1:0];
		end
	end

	// hue, sector and position within the sector
	always_comb begin
		sum_c = {1'b0, base_s4} + {1'b0, nhc_pkg::HUE_SHIFT};
		if (sum_c >= {1'b0, nhc_pkg::FULL_TURN}) begin
			sum_c = sum_c - {1'b0, nhc_pkg::FULL_TURN};
		end
		hue_c = sum_c[HW-1:0];

		if (hue_c < nhc_pkg::SECTOR_SPAN) begin
			sector_c = nhc_pkg::SEC_RED_GUP;
			off_c    = '0;
		end else if (hue_c < HW'(2 * nhc_pkg::SECTOR_SPAN)) begin
			sector_c = nhc_pkg::SEC_GRN_RDN;
			off_c    = nhc_pkg::SECTOR_SPAN;
		end else if (hue_c < HW'(3 * nhc_pkg::SECTOR_SPAN)) begin
			sector_c = nhc_pkg::SEC_GRN_BUP;
			off_c    = HW'(2 * nhc_pkg::SECTOR_SPAN);
		end else if (hue_c < HW'(4 * nhc_pkg::SECTOR_SPAN)) begin
			sector_c = nhc_pkg::SEC_BLU_GDN;
			off_c    = HW'(3 * nhc_pkg::SECTOR_SPAN);
		end else if (hue_c < HW'(5 * nhc_pkg::SECTOR_SPAN)) begin
			sector_c = nhc_pkg::SEC_BLU_RUP;
			off_c    = HW'(4 * nhc_pkg::SECTOR_SPAN);
		end else begin
			sector_c = nhc_pkg::SEC_RED_BDN;
			off_c    = HW'(5 * nhc_pkg::SECTOR_SPAN);
		end
	end

	assign hrem_c = JW'(hue_c - off_c);
	assign span_c = nhc_pkg::SECTOR_SPAN[JW-1:0];

	// per channel 60 - k: dominant 0, off 60, rising 60 - rem, falling rem
	always_comb begin
		unique case (sector_c)
			nhc_pkg::SEC_RED_GUP: begin
				jr_c = '0;
				jg_c = span_c - hrem_c;
				jb_c = span_c;
			end
			nhc_pkg::SEC_GRN_RDN: begin
				jr_c = hrem_c;
				jg_c = '0;
				jb_c = span_c;
			end
			nhc_pkg::SEC_GRN_BUP: begin
				jr_c = span_c;
				jg_c = '0;
				jb_c = span_c - hrem_c;
			end
			nhc_pkg::SEC_BLU_GDN: begin
				jr_c = span_c;
				jg_c = hrem_c;
				jb_c = '0;
			end
			nhc_pkg::SEC_BLU_RUP: begin
				jr_c = span_c - hrem_c;
				jg_c = span_c;
				jb_c = '0;
			end
			nhc_pkg::SEC_RED_BDN: begin
				jr_c = '0;
				jg_c = span_c;
				jb_c = hrem_c;
			end
			default: begin
				jr_c = '0;
				jg_c = '0;
				jb_c = '0;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ld1) begin
			r_s1  <= mod_c;
			vs_s1 <= VW'(saturation) * VW'(brightness);
			v_s1  <= brightness;
			a_s1  <= opacity;
		end
		if (ld2) begin
			num_s2 <= num_c;
			vk_s2  <= KW'(v_s1) * KW'(nhc_pkg::CHANNEL_DIV);
			vs_s2  <= vs_s1;
			a_s2   <= a_s1;
		end
		if (ld3) begin
			rem_s3 <= rem_hi_c;
			qh_s3  <= qh_c;
			lo_s3  <= num_s2[LO_STEPS-1:0];
			vk_s3  <= vk_s2;
			vs_s3  <= vs_s2;
			a_s3   <= a_s2;
		end
		if (ld4) begin
			base_s4 <= {qh_s3, ql_c};
			vk_s4   <= vk_s3;
			vs_s4   <= vs_s3;
			a_s4    <= a_s3;
		end
		if (ld5) begin
			jr_s5 <= jr_c;
			jg_s5 <= jg_c;
			jb_s5 <= jb_c;
			vk_s5 <= vk_s4;
			vs_s5 <= vs_s4;
			a_s5  <= a_s4;
		end
		if (ld6) begin
			a_s6 <= a_s5;
		end
		if (ld7) begin
			a_s7 <= a_s6;
		end
	end

	assign ctl.ld_s6 = ld6;
	assign ctl.ld_s7 = ld7;

	nhc_channel u_red (
		.clk   (clk),
		.ctl   (ctl),
		.vk    (vk_s5),
		.vs    (vs_s5),
		.j     (jr_s5),
		.value (red)
	);

	nhc_channel u_green (
		.clk   (clk),
		.ctl   (ctl),
		.vk    (vk_s5),
		.vs    (vs_s5),
		.j     (jg_s5),
		.value (green)
	);

	nhc_channel u_blue (
		.clk   (clk),
		.ctl   (ctl),
		.vk    (vk_s5),
		.vs    (vs_s5),
		.j     (jb_s5),
		.value (blue)
	);

	assign alpha_out = a_s7;

endmodule

FILE: tb/note_colour_checker.sv
`timescale 1ns / 1ps

module note_colour_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	input  logic                        note_valid,
	input  logic                        note_ready,
	input  logic [nhc_pkg::NOTE_W-1:0]  note_number,
	input  logic [nhc_pkg::CHAN_W-1:0]  saturation,
	input  logic [nhc_pkg::CHAN_W-1:0]  brightness,
	input  logic [nhc_pkg::CHAN_W-1:0]  opacity,
	input  logic                        rgb_valid,
	input  logic                        rgb_ready,
	input  logic [nhc_pkg::CHAN_W-1:0]  red,
	input  logic [nhc_pkg::CHAN_W-1:0]  green,
	input  logic [nhc_pkg::CHAN_W-1:0]  blue,
	input  logic [nhc_pkg::CHAN_W-1:0]  alpha_out,
	output int unsigned                 fail_count,
	output int unsigned                 colours_pending
);

	localparam logic [2:0] SEG_ADDR = {nhc_pkg::REG_SEGMENT_COUNT, 2'b00};

	typedef struct packed {
		logic [nhc_pkg::CHAN_W-1:0] red;
		logic [nhc_pkg::CHAN_W-1:0] green;
		logic [nhc_pkg::CHAN_W-1:0] blue;
		logic [nhc_pkg::CHAN_W-1:0] alpha;
	} colour_t;

	logic [nhc_pkg::SEG_W-1:0] seg_count = nhc_pkg::SEG_RESET;
	colour_t                   pending_colours[$];
	colour_t                   want;

	function automatic logic [nhc_pkg::CHAN_W-1:0] channel_level(input int unsigned v, s, k);
		int unsigned num;
		num = v * nhc_pkg::CHANNEL_DIV - v * s * nhc_pkg::SECTOR_SPAN + v * s * k;
		return nhc_pkg::CHAN_W'(num / nhc_pkg::CHANNEL_DIV);
	endfunction

	function automatic colour_t note_colour(input logic [nhc_pkg::NOTE_W-1:0] note,
			input logic [nhc_pkg::CHAN_W-1:0] s, v, a,
			input logic [nhc_pkg::SEG_W-1:0] seg_reg);
		int unsigned seg;
		int unsigned r;
		int unsigned base;
		int unsigned hue;
		int unsigned rem;
		int unsigned kr;
		int unsigned kg;
		int unsigned kb;
		nhc_pkg::nhc_sector_t sector;
		colour_t c;
		// zero segments behaves as a single segment
		seg = (seg_reg == 0) ? 1 : seg_reg;
		r = note % seg;
		base = (2 * r * nhc_pkg::FULL_TURN + seg) / (2 * seg);
		hue = (base + nhc_pkg::HUE_SHIFT) % nhc_pkg::FULL_TURN;
		sector = nhc_pkg::nhc_sector_t'(hue / nhc_pkg::SECTOR_SPAN);
		rem = hue % nhc_pkg::SECTOR_SPAN;
		case (sector)
			nhc_pkg::SEC_RED_GUP: begin
				kr = nhc_pkg::SECTOR_SPAN; kg = rem; kb = 0;
			end
			nhc_pkg::SEC_GRN_RDN: begin
				kr = nhc_pkg::SECTOR_SPAN - rem; kg = nhc_pkg::SECTOR_SPAN; kb = 0;
			end
			nhc_pkg::SEC_GRN_BUP: begin
				kr = 0; kg = nhc_pkg::SECTOR_SPAN; kb = rem;
			end
			nhc_pkg::SEC_BLU_GDN: begin
				kr = 0; kg = nhc_pkg::SECTOR_SPAN - rem; kb = nhc_pkg::SECTOR_SPAN;
			end
			nhc_pkg::SEC_BLU_RUP: begin
				kr = rem; kg = 0; kb = nhc_pkg::SECTOR_SPAN;
			end
			default: begin
				kr = nhc_pkg::SECTOR_SPAN; kg = 0; kb = nhc_pkg::SECTOR_SPAN - rem;
			end
		endcase
		c.red   = channel_level(v, s, kr);
		c.green = channel_level(v, s, kg);
		c.blue  = channel_level(v, s, kb);
		c.alpha = a;
		return c;
	endfunction

	task automatic check_field(input string field,
			input logic [nhc_pkg::CHAN_W-1:0] exp_val, got);
		if (got !== exp_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count = nhc_pkg::SEG_RESET;
			pending_colours.delete();
			colours_pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == SEG_ADDR)
				seg_count = pwdata[nhc_pkg::SEG_W-1:0];
			if (note_valid && note_ready)
				pending_colours.push_back(note_colour(note_number, saturation, brightness,
					opacity, seg_count));
			if (rgb_valid && rgb_ready) begin
				if (pending_colours.size() == 0) begin
					$error("colour result with no transaction waiting");
					fail_count++;
				end else begin
					want = pending_colours.pop_front();
					check_field("red", want.red, red);
					check_field("green", want.green, green);
					check_field("blue", want.blue, blue);
					check_field("alpha_out", want.alpha, alpha_out);
				end
			end
			colours_pending = pending_colours.size();
		end
	end

endmodule

FILE: tb/tb_note_hue_to_rgb_colour.sv
`timescale 1ns / 1ps

module tb_note_hue_to_rgb_colour;

	localparam logic [2:0] SEG_ADDR   = {nhc_pkg::REG_SEGMENT_COUNT, 2'b00};
	localparam logic [2:0] SPARE_ADDR = {~nhc_pkg::REG_SEGMENT_COUNT, 2'b00};
	localparam int PHASES          = 11;
	localparam int ITEMS_PER_PHASE = 98;

	typedef enum {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_BURSTY} rx_mode_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       psel        = 1'b0;
	logic                       penable     = 1'b0;
	logic                       pwrite      = 1'b0;
	logic [2:0]                 paddr       = '0;
	logic [31:0]                pwdata      = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       note_valid  = 1'b0;
	logic                       note_ready;
	logic [nhc_pkg::NOTE_W-1:0] note_number = '0;
	logic [nhc_pkg::CHAN_W-1:0] saturation  = '0;
	logic [nhc_pkg::CHAN_W-1:0] brightness  = '0;
	logic [nhc_pkg::CHAN_W-1:0] opacity     = '0;
	logic                       rgb_valid;
	logic                       rgb_ready   = 1'b0;
	logic [nhc_pkg::CHAN_W-1:0] red;
	logic [nhc_pkg::CHAN_W-1:0] green;
	logic [nhc_pkg::CHAN_W-1:0] blue;
	logic [nhc_pkg::CHAN_W-1:0] alpha_out;

	int unsigned fail_count;
	int unsigned colours_pending;

	int unsigned rx_cycle = 0;
	int unsigned rx_hold  = 0;
	rx_mode_t    rx_mode  = RX_ALWAYS;

	int unsigned burst_left;
	int unsigned seg_pick;

	note_hue_to_rgb_colour u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.note_valid  (note_valid),
		.note_ready  (note_ready),
		.note_number (note_number),
		.saturation  (saturation),
		.brightness  (brightness),
		.opacity     (opacity),
		.rgb_valid   (rgb_valid),
		.rgb_ready   (rgb_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha_out   (alpha_out)
	);

	note_colour_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.note_valid      (note_valid),
		.note_ready      (note_ready),
		.note_number     (note_number),
		.saturation      (saturation),
		.brightness      (brightness),
		.opacity         (opacity),
		.rgb_valid       (rgb_valid),
		.rgb_ready       (rgb_ready),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.alpha_out       (alpha_out),
		.fail_count      (fail_count),
		.colours_pending (colours_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver backpressure, switching at random among four styles
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 128 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_ALWAYS: rgb_ready = 1'b1;
			RX_COIN: rgb_ready = 1'($urandom_range(0, 1));
			RX_PATTERN: rgb_ready = (rx_cycle % 8) < 5;
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					rgb_ready = 1'b0;
				end else begin
					rgb_ready = 1'b1;
					if ($urandom_range(0, 15) == 0)
						rx_hold = $urandom_range(5, 20);
				end
			end
		endcase
	end

	task automatic send_note(input logic [nhc_pkg::NOTE_W-1:0] n,
			input logic [nhc_pkg::CHAN_W-1:0] s, v, a);
		@(negedge clk);
		note_valid  = 1'b1;
		note_number = n;
		saturation  = s;
		brightness  = v;
		opacity     = a;
		@(posedge clk);
		while (!note_ready)
			@(posedge clk);
	endtask

	task automatic sender_gap(input int unsigned cycles);
		@(negedge clk);
		note_valid  = 1'b0;
		note_number = nhc_pkg::NOTE_W'($urandom);
		saturation  = nhc_pkg::CHAN_W'($urandom);
		brightness  = nhc_pkg::CHAN_W'($urandom);
		opacity     = nhc_pkg::CHAN_W'($urandom);
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// drain the pipeline before touching the register
	task automatic wait_idle();
		@(negedge clk);
		note_valid = 1'b0;
		while (colours_pending != 0)
			@(negedge clk);
		repeat (10)
			@(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [nhc_pkg::SEG_W-1:0] value);
		wait_idle();
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = $urandom;
		pwdata[nhc_pkg::SEG_W-1:0] = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	function automatic logic [nhc_pkg::CHAN_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return nhc_pkg::CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;

		// reset segment count: every sector at full saturation
		for (int i = 0; i < 12; i++)
			send_note(nhc_pkg::NOTE_W'(i), 8'd255, 8'd255, 8'd255);
		send_note(7'd127, 8'd0, 8'd200, 8'd17);
		send_note(7'd0, 8'd255, 8'd0, 8'd0);
		send_note(7'd5, 8'd1, 8'd1, 8'd255);
		send_note(7'd127, 8'd128, 8'd255, 8'd0);

		apb_write(SEG_ADDR, 8'd0);
		send_note(7'd127, 8'd255, 8'd255, 8'd90);
		send_note(7'd33, 8'd200, 8'd100, 8'd1);

		apb_write(SEG_ADDR, 8'd128);
		send_note(7'd127, 8'd255, 8'd255, 8'd255);
		send_note(7'd64, 8'd255, 8'd255, 8'd0);

		apb_write(SEG_ADDR, 8'd255);
		send_note(7'd127, 8'd255, 8'd255, 8'd3);
		send_note(7'd100, 8'd170, 8'd240, 8'd128);

		// a write to an unused address leaves the segment count alone
		apb_write(SPARE_ADDR, 8'd1);
		send_note(7'd90, 8'd255, 8'd255, 8'd200);
		send_note(7'd45, 8'd77, 8'd255, 8'd60);

		apb_write(SEG_ADDR, 8'd1);
		send_note(7'd99, 8'd255, 8'd128, 8'd255);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: seg_pick = 1;
				1: seg_pick = 128;
				2: seg_pick = 0;
				3: seg_pick = 255;
				4: seg_pick = 12;
				5: seg_pick = $urandom_range(129, 254);
				default: seg_pick = $urandom_range(1, 128);
			endcase
			apb_write(SEG_ADDR, nhc_pkg::SEG_W'(seg_pick));
			burst_left = $urandom_range(1, 16);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_note(nhc_pkg::NOTE_W'($urandom_range(0, 127)), pick_level(),
					pick_level(), pick_level());
				burst_left--;
				if (burst_left == 0) begin
					if ($urandom_range(0, 3) != 0)
						sender_gap($urandom_range(1, 6));
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
						: $urandom_range(1, 16);
				end
			end
		end

		wait_idle();
		repeat (20)
			@(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: note_hue_to_rgb_colour.f
src/nhc_pkg.sv
src/nhc_channel.sv
src/note_hue_to_rgb_colour.sv
tb/note_colour_checker.sv
tb/tb_note_hue_to_rgb_colour.sv
